// File: rtl/bss_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command codes and the cell control struct for the substring search unit.
package bss_pkg;

   // Pattern store depth and width of the text offset counter.
   localparam int MAX_PATTERN   = 64;
   localparam int OFFSET_BITS   = 32;

   // Derived and fixed field widths.
   localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
   localparam int BYTE_BITS     = 8;
   localparam int CMD_BITS      = 2;
   localparam int POSITION_BITS = 32;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_END    = 2'd3
   } cmd_type;

   // Control broadcast from the top level to every cell of the row.
   typedef struct packed {
      logic                 rearm;
      logic                 update;
      logic                 write;
      logic [BYTE_BITS-1:0] data;
   } cell_ctrl_type;

endpackage

// File: rtl/bss_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
interface bss_req_if;
   import bss_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_BITS-1:0]  command;
   logic [BYTE_BITS-1:0] data;
   logic                 last;

   modport source (output valid, output command, output data, output last, input ready);
   modport sink   (input valid, input command, input data, input last, output ready);
endinterface

interface bss_rsp_if;
   import bss_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     found;
   logic [POSITION_BITS-1:0] position;
   logic                     pattern_too_long;

   modport source (output valid, output found, output position, output pattern_too_long,
                   input ready);
   modport sink   (input valid, input found, input position, input pattern_too_long,
                   output ready);
endinterface

// File: rtl/bss_cell.sv
`timescale 1ns / 1ps
// One search cell: a pattern byte and the prefix-match bit for its position.
module bss_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  bss_pkg::cell_ctrl_type ctrl,
   input  logic                  write_en,
   input  logic                  active,
   input  logic                  is_last,
   input  logic                  prev_in,
   output logic                  match_out,
   output logic                  hit_out
);
   import bss_pkg::*;

   logic [BYTE_BITS-1:0] pattern_byte_ff;
   logic                 matched_ff;
   logic                 matched_in;
   logic                 extend;

   // The prefix ending at the left neighbor grows by one if this byte agrees.
   assign extend = prev_in && (pattern_byte_ff == ctrl.data);

   always_comb begin
      matched_in = matched_ff;
      if (ctrl.rearm) begin
         matched_in = 1'b0;
      end else if (ctrl.update && active) begin
         matched_in = extend;
      end
   end

   assign hit_out   = ctrl.update && is_last && extend;
   assign match_out = matched_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff <= 1'b0;
      end else begin
         matched_ff <= matched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         pattern_byte_ff <= ctrl.data;
      end
   end

endmodule

// File: rtl/bss_cell_row.sv
`timescale 1ns / 1ps
// Row of search cells chained by their prefix-match bits, with the full-match detect.
module bss_cell_row (
   input  logic                          clock,
   input  logic                          reset,
   input  bss_pkg::cell_ctrl_type        ctrl,
   input  logic [bss_pkg::LEN_BITS-1:0]  pattern_length,
   output logic                          hit
);
   import bss_pkg::*;

   logic [MAX_PATTERN-1:0] matched;
   logic [MAX_PATTERN-1:0] hit_vec;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      logic prev;
      logic write_en;
      logic active;
      logic is_last;

      if (i == 0) begin : g_first
         assign prev = 1'b1;
      end else begin : g_next
         assign prev = matched[i-1];
      end

      assign write_en = ctrl.write && (LEN_BITS'(i) == pattern_length);
      assign active   = LEN_BITS'(i) < pattern_length;
      assign is_last  = LEN_BITS'(i + 1) == pattern_length;

      bss_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .write_en  (write_en),
         .active    (active),
         .is_last   (is_last),
         .prev_in   (prev),
         .match_out (matched[i]),
         .hit_out   (hit_vec[i])
      );
   end

   // Only the cell at the pattern's last position can raise a hit.
   assign hit = |hit_vec;

endmodule

// File: rtl/byte_substring_search_unit.sv
`timescale 1ns / 1ps
// Latency: a response is valid in the cycle after the request transfer that causes it.
// Throughput: one request per cycle; each text byte updates every cell of the row at once,
// and the single response register lets a request in only while empty or being drained.
// Reset (synchronous, active high) empties the pattern, clears the overflow flag, the prefix
// bits, the text offset and the response valid flag; pattern bytes are undefined until loaded.
// Top level of the streaming exact substring search unit.
module byte_substring_search_unit (
   input  logic      clock,
   input  logic      reset,
   bss_req_if.sink   req_ch,
   bss_rsp_if.source rsp_ch
);
   import bss_pkg::*;

   localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_PATTERN);

   // Search state.
   logic [LEN_BITS-1:0]      pattern_length_ff, pattern_length_in;
   logic                     overflowed_ff, overflowed_in;
   logic [OFFSET_BITS-1:0]   text_offset_ff, text_offset_in;
   logic                     result_given_ff, result_given_in;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff, found_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic                     too_long_ff, too_long_in;

   logic                     fire;
   cmd_type                  command;
   cell_ctrl_type            ctrl;
   logic                     row_hit;
   logic                     search;
   logic                     hit;
   logic                     emit;
   logic [OFFSET_BITS-1:0]   back;
   logic [OFFSET_BITS-1:0]   match_start;

   // A new request is taken whenever the response register is empty or is being drained
   // in this same cycle, so a waiting result stalls the stream only while it is not taken.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;
   assign command      = cmd_type'(req_ch.command);

   // The row only advances on text bytes while the search is still open and the
   // pattern is both non-empty and complete.
   assign search = !result_given_ff && !overflowed_ff;

   always_comb begin
      ctrl.data   = req_ch.data;
      ctrl.write  = fire && (command == CMD_APPEND) && (pattern_length_ff < MAX_LEN);
      ctrl.update = fire && (command == CMD_TEXT) && search && (pattern_length_ff != '0);
      ctrl.rearm  = fire && ((command != CMD_TEXT) || req_ch.last);
   end

   bss_cell_row u_row (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .pattern_length (pattern_length_ff),
      .hit            (row_hit)
   );

   // The match started pattern_length - 1 bytes before the current offset. If the offset
   // is smaller than that distance, the start is clamped at zero.
   assign back        = OFFSET_BITS'(pattern_length_ff) - OFFSET_BITS'(1);
   assign match_start = (text_offset_ff >= back) ? (text_offset_ff - back) : '0;

   // An empty pattern matches at the very first text byte.
   assign hit = (pattern_length_ff == '0) ? search : row_hit;

   always_comb begin
      pattern_length_in = pattern_length_ff;
      overflowed_in     = overflowed_ff;
      text_offset_in    = text_offset_ff;
      result_given_in   = result_given_ff;
      emit              = 1'b0;
      found_in          = found_ff;
      position_in       = position_ff;
      too_long_in       = too_long_ff;

      if (fire) begin
         case (command)
            CMD_CLEAR: begin
               pattern_length_in = '0;
               overflowed_in     = 1'b0;
            end
            CMD_APPEND: begin
               if (pattern_length_ff < MAX_LEN) begin
                  pattern_length_in = pattern_length_ff + LEN_BITS'(1);
               end else begin
                  overflowed_in = 1'b1;
               end
            end
            CMD_END: begin
               if (!result_given_ff) begin
                  emit        = 1'b1;
                  found_in    = (pattern_length_ff == '0) && !overflowed_ff;
                  position_in = '0;
                  too_long_in = overflowed_ff;
               end
            end
            CMD_TEXT: begin
               if (hit) begin
                  emit            = 1'b1;
                  found_in        = 1'b1;
                  position_in     = (pattern_length_ff == '0) ? '0
                                                              : POSITION_BITS'(match_start);
                  too_long_in     = 1'b0;
                  result_given_in = 1'b1;
               end else if (req_ch.last && !result_given_ff) begin
                  // Text ended without a match: report not found once.
                  emit        = 1'b1;
                  found_in    = 1'b0;
                  position_in = '0;
                  too_long_in = overflowed_ff;
               end
               if (text_offset_ff != '1) begin
                  text_offset_in = text_offset_ff + OFFSET_BITS'(1);
               end
            end
            default: begin
            end
         endcase

         // Every command but a non-final text byte starts the next text afresh.
         if (ctrl.rearm) begin
            text_offset_in  = '0;
            result_given_in = 1'b0;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         overflowed_ff     <= 1'b0;
         text_offset_ff    <= '0;
         result_given_ff   <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         overflowed_ff     <= overflowed_in;
         text_offset_ff    <= text_offset_in;
         result_given_ff   <= result_given_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      position_ff <= position_in;
      too_long_ff <= too_long_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.found            = found_ff;
   assign rsp_ch.position         = position_ff;
   assign rsp_ch.pattern_too_long = too_long_ff;

endmodule

// File: verif/search_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the results of the substring search unit.
package search_scoreboard_pkg;
   import bss_pkg::*;

   typedef struct packed {
      logic                     found;
      logic [POSITION_BITS-1:0] position;
      logic                     too_long;
   } search_result_type;

   class search_scoreboard_type;
      logic [BYTE_BITS-1:0]   pat_bytes [MAX_PATTERN];
      int                     pat_len;
      logic [MAX_PATTERN-1:0] match_row;
      logic [OFFSET_BITS-1:0] text_pos;
      bit                     reported;
      bit                     dropped;
      search_result_type      pending_results [$];
      int                     errors;
      int                     results_seen;

      function new();
         pat_len      = 0;
         dropped      = 0;
         errors       = 0;
         results_seen = 0;
         restart_text();
      endfunction

      function void restart_text();
         match_row = '0;
         text_pos  = '0;
         reported  = 0;
      endfunction

      function void push_result(logic found, logic [OFFSET_BITS-1:0] pos, logic too_long);
         search_result_type r;
         r.found    = found;
         r.position = found ? pos[POSITION_BITS-1:0] : '0;
         r.too_long = too_long;
         pending_results.push_back(r);
         reported = 1;
      endfunction

      // Advances the predicted state by one accepted request.
      function void note_request(cmd_type cmd, logic [BYTE_BITS-1:0] data, logic last);
         logic [MAX_PATTERN-1:0] next_row;
         logic [OFFSET_BITS-1:0] back;
         case (cmd)
            CMD_CLEAR: begin
               pat_len = 0;
               dropped = 0;
               restart_text();
            end
            CMD_APPEND: begin
               if (pat_len < MAX_PATTERN) begin
                  pat_bytes[pat_len] = data;
                  pat_len++;
               end else begin
                  dropped = 1;
               end
               restart_text();
            end
            CMD_END: begin
               if (!reported) push_result(pat_len == 0 && !dropped, '0, dropped);
               restart_text();
            end
            default: begin
               if (!reported && !dropped) begin
                  if (pat_len == 0) begin
                     push_result(1'b1, '0, 1'b0);
                  end else begin
                     next_row = '0;
                     for (int i = 0; i < pat_len; i++)
                        next_row[i] = (i == 0 ? 1'b1 : match_row[i-1]) && pat_bytes[i] == data;
                     match_row = next_row;
                     if (match_row[pat_len-1]) begin
                        back = OFFSET_BITS'(pat_len - 1);
                        push_result(1'b1, (text_pos >= back) ? text_pos - back : '0, 1'b0);
                     end
                  end
               end
               if (text_pos != '1) text_pos++;
               if (last) begin
                  if (!reported) push_result(1'b0, '0, dropped);
                  restart_text();
               end
            end
         endcase
      endfunction

      function void report_field(string name, logic [POSITION_BITS-1:0] want,
                                 logic [POSITION_BITS-1:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      endfunction

      // Compares one accepted result with the oldest prediction.
      function void check_response(logic found, logic [POSITION_BITS-1:0] position,
                                   logic too_long);
         search_result_type w;
         results_seen++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual found=%0d pos=%0d tl=%0d",
                     $time, found, position, too_long);
            return;
         end
         w = pending_results.pop_front();
         if (found !== w.found) report_field("found", w.found, found);
         if (position !== w.position) report_field("position", w.position, position);
         if (too_long !== w.too_long) report_field("pattern_too_long", w.too_long, too_long);
      endfunction

      function void report_leftover();
         if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results expected but never delivered, actual none",
                     $time, pending_results.size());
         end
      endfunction
   endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench of the byte substring search unit.
module tb_top;
   import bss_pkg::*;
   import search_scoreboard_pkg::*;

   logic clock = 1'b0;
   logic reset;

   bss_req_if req_ch ();
   bss_rsp_if rsp_ch ();

   byte_substring_search_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // A 12 ns clock period.
   always #6 clock = ~clock;

   search_scoreboard_type sb = new();

   // Number of request transfers so far, used only to decide when the stimulus stops.
   int requests_sent = 0;

   // When set, both sides stop inserting idle cycles, giving back-to-back transfers.
   bit no_idle = 0;

   // The sender asks for a long receiver stall by raising this count. The receiver
   // serves each request with a stall that it counts in its own process.
   int hold_requests = 0;

   // Drives one request and waits for its transfer. The sender may idle first.
   // Valid is only lowered in the idle cycles, so a back-to-back item just gets
   // new payload while valid stays high.
   task automatic send_request(input cmd_type cmd, input logic [BYTE_BITS-1:0] data,
                               input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.data    <= data;
      req_ch.last    <= last;
      // Sampling at the edge sees the values that decide the transfer at that edge.
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(cmd, data, last);
      requests_sent++;
   endtask

   // Sends a text. An empty text, or one that the caller wants closed by an
   // explicit end command, finishes with the end command; otherwise the final
   // byte carries the last flag.
   task automatic send_text(input logic [BYTE_BITS-1:0] text [$], input bit close_with_end);
      for (int i = 0; i < text.size(); i++)
         send_request(CMD_TEXT, text[i], !close_with_end && i == text.size() - 1);
      if (close_with_end || text.size() == 0)
         send_request(CMD_END, 8'($urandom), 1'($urandom));
   endtask

   // A fixed opening that covers the edge cases before the random traffic.
   task automatic run_directed();
      // With an empty pattern, an empty text matches at offset zero.
      send_request(CMD_END, 8'h00, 1'b0);
      // With an empty pattern, the first text byte reports the match at offset zero.
      send_request(CMD_TEXT, 8'h00, 1'b0);
      // Bytes after a match are ignored and the end of the text reports nothing.
      send_request(CMD_TEXT, 8'hFF, 1'b0);
      send_request(CMD_END, 8'hFF, 1'b1);
      // A single byte that is also the last one gives just the one match result.
      send_request(CMD_TEXT, 8'h5A, 1'b1);
      // Two-byte pattern using both byte extremes; the last flag is ignored on append.
      send_request(CMD_APPEND, 8'h00, 1'b1);
      send_request(CMD_APPEND, 8'hFF, 1'b0);
      // The pattern is longer than an empty text or a one-byte text.
      send_request(CMD_END, 8'h00, 1'b0);
      send_request(CMD_TEXT, 8'h00, 1'b1);
      // Match at offset one, then a trailing last byte that must not report again.
      send_request(CMD_TEXT, 8'hFF, 1'b0);
      send_request(CMD_TEXT, 8'h00, 1'b0);
      send_request(CMD_TEXT, 8'hFF, 1'b0);
      send_request(CMD_TEXT, 8'h00, 1'b1);
      // Clear ignores its data and last fields.
      send_request(CMD_CLEAR, 8'hA5, 1'b1);
      // Overlapping prefix: "aab" in "aaab" starts at offset one.
      send_request(CMD_APPEND, 8'h61, 1'b0);
      send_request(CMD_APPEND, 8'h61, 1'b0);
      send_request(CMD_APPEND, 8'h62, 1'b0);
      send_request(CMD_TEXT, 8'h61, 1'b0);
      send_request(CMD_TEXT, 8'h61, 1'b0);
      send_request(CMD_TEXT, 8'h61, 1'b0);
      send_request(CMD_TEXT, 8'h62, 1'b1);
      // A one-byte text that does not contain the pattern.
      send_request(CMD_TEXT, 8'h62, 1'b1);
   endtask

   // Fills the result path: the receiver stalls for a long time while the sender
   // keeps offering end commands, each of which reports an empty-pattern match.
   task automatic run_backpressure();
      send_request(CMD_CLEAR, 8'h00, 1'b0);
      no_idle = 1;
      hold_requests <= hold_requests + 1;
      repeat (30) send_request(CMD_END, 8'h00, 1'b0);
      no_idle = 0;
   endtask

   // One random session: a fresh pattern followed by one to four texts, with some
   // noise items mixed in to break the usual order of commands.
   task automatic run_session();
      logic [BYTE_BITS-1:0] pattern [$];
      logic [BYTE_BITS-1:0] text [$];
      logic [BYTE_BITS-1:0] alphabet [3];
      bit narrow;
      int plen;
      int tlen;
      int at;
      int pick;

      no_idle = ($urandom_range(0, 5) == 0);
      narrow  = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < 3; i++) alphabet[i] = 8'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 5) plen = 0;
      else if (pick < 11) plen = $urandom_range(MAX_PATTERN - 2, MAX_PATTERN + 4);
      else plen = $urandom_range(1, 8);

      send_request(CMD_CLEAR, 8'($urandom), 1'($urandom));
      for (int i = 0; i < plen; i++) begin
         pattern.push_back(narrow ? alphabet[$urandom_range(0, 2)] : 8'($urandom));
         send_request(CMD_APPEND, pattern[i], 1'($urandom));
      end

      repeat ($urandom_range(1, 4)) begin
         text.delete();
         tlen = (plen > 16) ? $urandom_range(0, 90) : $urandom_range(0, 24);
         for (int i = 0; i < tlen; i++)
            text.push_back(narrow ? alphabet[$urandom_range(0, 2)] : 8'($urandom));
         // Plant the pattern now and then so that long patterns also find matches.
         if (plen > 0 && plen <= tlen && $urandom_range(0, 9) < 4) begin
            at = $urandom_range(0, tlen - plen);
            for (int i = 0; i < plen && i < MAX_PATTERN; i++) text[at + i] = pattern[i];
         end
         send_text(text, $urandom_range(0, 9) < 3);
         // Noise: any command with any payload, including appends in mid-text.
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
               send_request(cmd_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      end
      no_idle = 0;
   endtask

   // Receiver: checks every accepted result and throttles ready. It draws a random
   // stall after each result and serves long stall requests.
   initial begin
      int idle_left;
      int hold_left;
      int holds_served;
      idle_left    = 0;
      hold_left    = 0;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_response(rsp_ch.found, rsp_ch.position, rsp_ch.pattern_too_long);
            idle_left = no_idle ? 0 : $urandom_range(0, 6);
         end
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Main sequence: reset, directed cases, the long stall, then random sessions.
   // When everything is sent, wait for outstanding results, then wait on for
   // any stray extra result, then give the verdict.
   initial begin
      int waited;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.command <= CMD_CLEAR;
      req_ch.data    <= '0;
      req_ch.last    <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_backpressure();
      while (requests_sent < 825) run_session();
      req_ch.valid <= 1'b0;

      waited = 0;
      while (sb.pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      sb.report_leftover();

      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
